// ===== src/rwc_pkg.sv =====
// Shared types and fixed constants for the RGB window convolution block.
package rwc_pkg;

   localparam int NCOEF      = 49;   // coefficient grid, 7 by 7
   localparam int NCOEF_W    = 6;
   localparam int MAX_HEIGHT = 4096;
   localparam int ROW_W      = 13;   // holds MAX_HEIGHT
   localparam int PIX_W      = 24;
   localparam int COEF_W     = 16;
   localparam int PROD_W     = 25;
   localparam int ACC_W      = 40;

   // request kinds carried on req_tuser
   localparam logic [1:0] REQ_COEF  = 2'd0;
   localparam logic [1:0] REQ_PIXEL = 2'd1;
   localparam logic [1:0] REQ_FLUSH = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_RADIUS = 2'd2;

   typedef struct packed {
      logic clear;    // start of a new output sum
      logic vld;      // pixel and coefficient read data present
      logic tap_ok;   // tap lies inside image and grid, coefficient loaded
   } mac_ctrl_type;

endpackage

// ===== src/rwc_mac.sv =====
// Three-channel multiply-accumulate with clamp to 0..255.
module rwc_mac
   import rwc_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mac_ctrl_type             ctrl,
   input  logic [PIX_W-1:0]         pix,
   input  logic signed [COEF_W-1:0] coef,
   output logic [PIX_W-1:0]         rgb
);

   logic signed [PROD_W-1:0] prod_ff [3];
   logic                     pvld_ff;
   logic signed [ACC_W-1:0]  acc_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= ctrl.vld;
      end
      for (int c = 0; c < 3; c++) begin
         if (ctrl.vld) begin
            if (ctrl.tap_ok) begin
               prod_ff[c] <= PROD_W'(signed'({1'b0, pix[8*c +: 8]})) * PROD_W'(coef);
            end else begin
               prod_ff[c] <= '0;
            end
         end
         if (ctrl.clear) begin
            acc_ff[c] <= '0;
         end else if (pvld_ff) begin
            acc_ff[c] <= acc_ff[c] + ACC_W'(prod_ff[c]);
         end
      end
   end

   always_comb begin
      logic signed [ACC_W-1:0] sh;
      for (int c = 0; c < 3; c++) begin
         sh = acc_ff[c] >>> COEF_FRAC_BITS;
         if (acc_ff[c] < 0) begin
            rgb[8*c +: 8] = 8'd0;
         end else if (sh > ACC_W'(255)) begin
            rgb[8*c +: 8] = 8'd255;
         end else begin
            rgb[8*c +: 8] = sh[7:0];
         end
      end
   end

endmodule

// ===== src/rgb_window_convolution.sv =====
// RGB window convolution: zero-padded square kernel over a raster stream.
// Requests are taken only while idle; an item that yields a result holds off the next one
//   until its result is registered. The tap loop reads one row store entry and one coefficient
//   per cycle through a single read port.
// Reset: synchronous, active high; clears counters, coefficient valid bits and registers
//   (640 x 480, radius 1). The row store is not cleared.
module rgb_window_convolution
   import rwc_pkg::*;
#(
   parameter int MAX_WIDTH      = 1024,
   parameter int MAX_RADIUS     = 3,
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   // request items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // coef_index[5:0], coef_value[21:6], red_in[29:22],
                                   // green_in[37:30], blue_in[45:38], zero fill
   input  logic [1:0]  req_tuser,  // req_type[1:0]
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // red_out[7:0], green_out[15:8], blue_out[23:16]
   output logic        rsp_tlast,  // frame_end
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   localparam int SLOTS = 2 * MAX_RADIUS + 2;     // rows held in the row store
   localparam int GRID  = 2 * MAX_RADIUS + 1;
   localparam int DEPTH = SLOTS * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int SW    = $clog2(SLOTS);
   localparam int TW    = $clog2(GRID);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int CIW   = $clog2(GRID * GRID);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_TAPS, ST_DRAIN_A, ST_DRAIN_B, ST_FINISH
   } state_type;

   // request fields
   logic [NCOEF_W-1:0]       coef_index;
   logic [COEF_W-1:0]        coef_value;
   logic [7:0]               red_in, green_in, blue_in;
   assign coef_index = req_tdata[5:0];
   assign coef_value = req_tdata[21:6];
   assign red_in     = req_tdata[29:22];
   assign green_in   = req_tdata[37:30];
   assign blue_in    = req_tdata[45:38];

   // registers
   logic [10:0]              width_ff;
   logic [12:0]              height_ff;
   logic [1:0]               radius_ff;

   // storage
   logic [PIX_W-1:0]         row_mem [DEPTH];
   logic [COEF_W-1:0]        coef_mem [NCOEF];
   logic [NCOEF-1:0]         coef_vld_ff;

   // positions; slots track row modulo SLOTS
   logic [CW-1:0]            in_col_ff, out_col_ff;
   logic [ROW_W-1:0]         in_row_ff, out_row_ff;
   logic [SW-1:0]            in_slot_ff, out_slot_ff;
   logic                     done_ff;   // whole frame received

   state_type                state_ff;
   logic [TW-1:0]            ty_ff, tx_ff;

   // tap read stage
   logic [PIX_W-1:0]         pix_ff;
   logic [COEF_W-1:0]        coef_rd_ff;
   logic                     coef_hit_ff;
   logic                     rd_vld_ff, rd_ok_ff;

   // result register
   logic                     rsp_valid_ff, rsp_last_ff;
   logic [23:0]              rsp_data_ff;

   logic [CW-1:0]            w_eff;
   logic [ROW_W-1:0]         h_eff;
   logic [RW-1:0]            r_eff;
   logic [TW-1:0]            r_last;     // 2r

   always_comb begin
      if (width_ff == 11'd0) begin
         w_eff = CW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(width_ff);
      end
      if (height_ff == 13'd0) begin
         h_eff = ROW_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = ROW_W'(MAX_HEIGHT);
      end else begin
         h_eff = ROW_W'(height_ff);
      end
      if (32'(radius_ff) > MAX_RADIUS) begin
         r_eff = RW'(MAX_RADIUS);
      end else begin
         r_eff = RW'(radius_ff);
      end
      r_last = TW'(2 * 32'(r_eff));
   end

   wire accept = req_tvalid && req_tready;
   wire is_pix = accept && (req_tuser == REQ_PIXEL);

   // input position: wrap stale position, then advance past the new pixel
   logic [CW-1:0]    col_a, col_in;
   logic [ROW_W-1:0] row_a, row_in;
   logic [SW-1:0]    slot_a, slot_in;
   logic             frame_in, emit_in;
   logic [AW-1:0]    wr_addr;

   always_comb begin
      col_a  = in_col_ff;
      row_a  = in_row_ff;
      slot_a = in_slot_ff;
      if (in_col_ff >= w_eff) begin
         col_a  = '0;
         row_a  = in_row_ff + 1'b1;
         slot_a = (in_slot_ff == SW'(SLOTS - 1)) ? '0 : in_slot_ff + 1'b1;
      end
      if (row_a >= h_eff) begin
         row_a  = '0;
         slot_a = '0;
      end
      wr_addr = AW'(32'(slot_a) * MAX_WIDTH + 32'(col_a));
      // raster position against the lag of r rows and r pixels; narrow rows wrap
      emit_in = (32'(row_a) * 32'(w_eff) + 32'(col_a))
             >= (32'(r_eff) * 32'(w_eff) + 32'(r_eff));
      col_in   = col_a + 1'b1;
      row_in   = row_a;
      slot_in  = slot_a;
      frame_in = 1'b0;
      if (col_in >= w_eff) begin
         col_in  = '0;
         row_in  = row_a + 1'b1;
         slot_in = (slot_a == SW'(SLOTS - 1)) ? '0 : slot_a + 1'b1;
         if (row_in >= h_eff) begin
            row_in   = '0;
            slot_in  = '0;
            frame_in = 1'b1;
         end
      end
   end

   // output position wrap at the start of a sum
   logic [CW-1:0]    ocol_w;
   logic [ROW_W-1:0] orow_w;
   logic [SW-1:0]    oslot_w;

   always_comb begin
      ocol_w  = out_col_ff;
      orow_w  = out_row_ff;
      oslot_w = out_slot_ff;
      if (out_col_ff >= w_eff) begin
         ocol_w  = '0;
         orow_w  = out_row_ff + 1'b1;
         oslot_w = (out_slot_ff == SW'(SLOTS - 1)) ? '0 : out_slot_ff + 1'b1;
      end
      if (orow_w >= h_eff) begin
         orow_w  = '0;
         oslot_w = '0;
      end
   end

   // tap address for the current (ty, tx)
   logic signed [ROW_W+1:0] iy;
   logic signed [CW+1:0]    ix;
   logic signed [SW+1:0]    tslot;
   logic [CIW-1:0]          cidx;
   logic                    tap_ok;
   logic [AW-1:0]           rd_addr;

   always_comb begin
      iy    = signed'((ROW_W+2)'(out_row_ff)) + signed'((ROW_W+2)'(ty_ff))
            - signed'((ROW_W+2)'(r_eff));
      ix    = signed'((CW+2)'(out_col_ff)) + signed'((CW+2)'(tx_ff))
            - signed'((CW+2)'(r_eff));
      tslot = signed'((SW+2)'(out_slot_ff)) + signed'((SW+2)'(ty_ff))
            - signed'((SW+2)'(r_eff));
      if (tslot < 0) begin
         tslot = tslot + (SW+2)'(SLOTS);
      end else if (tslot >= (SW+2)'(SLOTS)) begin
         tslot = tslot - (SW+2)'(SLOTS);
      end
      cidx   = CIW'(32'(ty_ff) * GRID + 32'(tx_ff));
      tap_ok = (iy >= 0) && (iy < signed'((ROW_W+2)'(h_eff)))
            && (ix >= 0) && (ix < signed'((CW+2)'(w_eff)))
            && (32'(cidx) < NCOEF);
      rd_addr = AW'(32'(tslot[SW-1:0]) * MAX_WIDTH + 32'(ix[CW-1:0]));
   end

   wire rd_en = (state_ff == ST_TAPS) && tap_ok;

   // memories
   always_ff @(posedge clock) begin
      if (is_pix) begin
         row_mem[wr_addr] <= {red_in, green_in, blue_in};
      end
      if (rd_en) begin
         pix_ff     <= row_mem[rd_addr];
         coef_rd_ff <= coef_mem[cidx[NCOEF_W-1:0]];
      end
      if (accept && (req_tuser == REQ_COEF) && (32'(coef_index) < NCOEF)) begin
         coef_mem[coef_index] <= coef_value;
      end
   end

   // packed pixel is r,g,b from the top; the MAC takes red in the low byte, as rsp_tdata
   mac_ctrl_type     mac_ctrl;
   logic [PIX_W-1:0] mac_rgb;

   assign mac_ctrl.clear  = (state_ff == ST_SETUP);
   assign mac_ctrl.vld    = rd_vld_ff;
   assign mac_ctrl.tap_ok = rd_ok_ff && coef_hit_ff;

   rwc_mac #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .pix   ({pix_ff[7:0], pix_ff[15:8], pix_ff[23:16]}),
      .coef  (signed'(coef_rd_ff)),
      .rgb   (mac_rgb)
   );

   // output advance after a sum
   logic [CW-1:0]    ocol_in;
   logic [ROW_W-1:0] orow_in;
   logic [SW-1:0]    oslot_in;
   logic             oend_in;

   always_comb begin
      ocol_in  = out_col_ff + 1'b1;
      orow_in  = out_row_ff;
      oslot_in = out_slot_ff;
      oend_in  = 1'b0;
      if (ocol_in >= w_eff) begin
         ocol_in  = '0;
         orow_in  = out_row_ff + 1'b1;
         oslot_in = (out_slot_ff == SW'(SLOTS - 1)) ? '0 : out_slot_ff + 1'b1;
         if (orow_in >= h_eff) begin
            orow_in  = '0;
            oslot_in = '0;
            oend_in  = 1'b1;
         end
      end
   end

   wire rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= 11'd640;
         height_ff    <= 13'd480;
         radius_ff    <= 2'd1;
         coef_vld_ff  <= '0;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_slot_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_slot_ff  <= '0;
         done_ff      <= 1'b0;
         ty_ff        <= '0;
         tx_ff        <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_WIDTH:  width_ff  <= csr_data[10:0];
               CSR_HEIGHT: height_ff <= csr_data;
               CSR_RADIUS: radius_ff <= csr_data[1:0];
               default: ;
            endcase
         end
         // in ST_FINISH the result register is handled below
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_vld_ff <= (state_ff == ST_TAPS);
         rd_ok_ff  <= tap_ok;
         if (rd_en) begin
            coef_hit_ff <= coef_vld_ff[cidx[NCOEF_W-1:0]];
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_tuser)
                     REQ_COEF: begin
                        if (32'(coef_index) < NCOEF) begin
                           coef_vld_ff[coef_index] <= 1'b1;
                        end
                     end
                     REQ_PIXEL: begin
                        // a pixel after a received frame starts the next one
                        if (done_ff) begin
                           out_col_ff  <= '0;
                           out_row_ff  <= '0;
                           out_slot_ff <= '0;
                        end
                        done_ff    <= frame_in;
                        in_col_ff  <= col_in;
                        in_row_ff  <= row_in;
                        in_slot_ff <= slot_in;
                        if (emit_in) begin
                           state_ff <= ST_SETUP;
                        end
                     end
                     REQ_FLUSH: begin
                        if (done_ff) begin
                           state_ff <= ST_SETUP;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_SETUP: begin
               out_col_ff  <= ocol_w;
               out_row_ff  <= orow_w;
               out_slot_ff <= oslot_w;
               ty_ff       <= '0;
               tx_ff       <= '0;
               state_ff    <= ST_TAPS;
            end
            ST_TAPS: begin
               if (tx_ff == r_last) begin
                  tx_ff <= '0;
                  if (ty_ff == r_last) begin
                     state_ff <= ST_DRAIN_A;
                  end else begin
                     ty_ff <= ty_ff + 1'b1;
                  end
               end else begin
                  tx_ff <= tx_ff + 1'b1;
               end
            end
            ST_DRAIN_A: state_ff <= ST_DRAIN_B;
            ST_DRAIN_B: state_ff <= ST_FINISH;
            ST_FINISH: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= mac_rgb;
                  rsp_last_ff  <= oend_in;
                  out_col_ff   <= ocol_in;
                  out_row_ff   <= orow_in;
                  out_slot_ff  <= oslot_in;
                  if (oend_in) begin
                     done_ff <= 1'b0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== src/rwc_checker.sv =====
// Port-level checks for the RGB window convolution, bound to the top level.
module rwc_checker
   import rwc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   // a new result is only produced while requests are held off
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while block was idle");

   // a coefficient write keeps the block idle, so requests stay ready
   a_coef_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == REQ_COEF) |=> req_tready)
      else $error("coefficient write stalled the request side");

endmodule

bind rgb_window_convolution rwc_checker u_rwc_checker (.*);

// ===== tb/sv/tb_rgb_window_convolution.sv =====
// Self-checking testbench for rgb_window_convolution: frames, flushes and kernel loads.
module tb_rgb_window_convolution;
   import rwc_pkg::*;

   localparam int MAX_W    = 1024;
   localparam int MAX_R    = 3;
   localparam int FRAC     = 12;
   localparam int GRID     = 2 * MAX_R + 1;
   localparam int SLOTS    = 2 * MAX_R + 2;
   localparam int LIMIT    = 20000;  // cycles with no handshake anywhere
   localparam int SETTLE   = 60;     // settle time after the last result, sized for a full tap loop at radius 3
   localparam logic [1:0] REQ_NONE = 2'd3;  // unused kind, block must ignore it

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } pixel_out_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = REQ_COEF;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_WIDTH;
   logic [12:0] csr_data = '0;

   rgb_window_convolution uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [23:0]        pix_store [MAX_W * SLOTS];
   logic signed [15:0] kernel [NCOEF];
   int unsigned        in_col, in_row, out_col, out_row;
   bit                 frame_rcvd;
   logic [10:0]        cfg_width;
   logic [12:0]        cfg_height;
   logic [1:0]         cfg_radius;

   pixel_out_t exp_pixels[$];
   int         mismatches = 0;
   int         sender_idle = 38;
   int         receiver_idle = 76;
   int         item_count;
   int         stall_count = 0;

   function automatic int unsigned eff_width();
      if (cfg_width == 0) return 1;
      return (cfg_width > MAX_W) ? MAX_W : cfg_width;
   endfunction

   function automatic int unsigned eff_height();
      if (cfg_height == 0) return 1;
      return (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
   endfunction

   function automatic logic [7:0] clamp8(longint acc);
      if (acc < 0) return 8'd0;
      acc = acc >>> FRAC;
      return (acc > 255) ? 8'd255 : acc[7:0];
   endfunction

   // filtered pixel at the output position, then step the output position
   function automatic void emit_filtered();
      int unsigned w, h;
      int          r, iy, ix;
      longint      sr, sg, sb, c;
      logic [23:0] px;
      pixel_out_t  o;
      w = eff_width();
      h = eff_height();
      r = cfg_radius;
      sr = 0; sg = 0; sb = 0;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      if (out_row >= h) out_row = 0;
      for (int dy = -r; dy <= r; dy++) begin
         for (int dx = -r; dx <= r; dx++) begin
            iy = int'(out_row) + dy;
            ix = int'(out_col) + dx;
            if (iy < 0 || ix < 0 || iy >= int'(h) || ix >= int'(w)) continue;
            px = pix_store[(iy % SLOTS) * MAX_W + ix];
            c = kernel[(dy + r) * GRID + (dx + r)];
            sr += longint'(px[23:16]) * c;
            sg += longint'(px[15:8]) * c;
            sb += longint'(px[7:0]) * c;
         end
      end
      o.red = clamp8(sr);
      o.green = clamp8(sg);
      o.blue = clamp8(sb);
      o.last = 1'b0;
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
         if (out_row >= h) begin
            out_row = 0;
            o.last = 1'b1;
            frame_rcvd = 0;
         end
      end
      exp_pixels.push_back(o);
   endfunction

   function automatic void predict_item(logic [1:0] kind, logic [47:0] d);
      int unsigned w, h, r, pos;
      w = eff_width();
      h = eff_height();
      r = cfg_radius;
      case (kind)
         REQ_COEF: begin
            if (d[5:0] < NCOEF) kernel[d[5:0]] = d[21:6];
         end
         REQ_PIXEL: begin
            if (frame_rcvd) begin
               // new frame: outputs still pending are dropped
               frame_rcvd = 0;
               out_col = 0;
               out_row = 0;
            end
            if (in_col >= w) begin
               in_col = 0;
               in_row++;
            end
            if (in_row >= h) in_row = 0;
            pix_store[(in_row % SLOTS) * MAX_W + in_col] = {d[29:22], d[37:30], d[45:38]};
            pos = in_row * w + in_col;
            in_col++;
            if (in_col >= w) begin
               in_col = 0;
               in_row++;
               if (in_row >= h) begin
                  in_row = 0;
                  frame_rcvd = 1;
               end
            end
            if (pos >= r * w + r) emit_filtered();
         end
         REQ_FLUSH: begin
            if (frame_rcvd) emit_filtered();
         end
         default: ;
      endcase
   endfunction

   // sender side: random gaps, inputs change on the falling edge
   task automatic send_item(logic [1:0] kind, logic [47:0] d);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tuser = kind;
      req_tdata = d;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_item(kind, d);
      if (kind != REQ_NONE) item_count++;
   endtask

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      send_item(REQ_PIXEL, {2'b00, b, g, r, 16'h0000, 6'd0});
   endtask

   task automatic send_coef(logic [5:0] idx, logic [15:0] val);
      send_item(REQ_COEF, {26'd0, val, idx});
   endtask

   task automatic send_flush();
      send_item(REQ_FLUSH, 48'd0);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [12:0] val);
      @(negedge clock);
      req_tvalid = 1'b0;
      csr_index = idx;
      csr_data = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WIDTH:  cfg_width = val[10:0];
         CSR_HEIGHT: cfg_height = val;
         CSR_RADIUS: cfg_radius = val[1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // wait for every expected pixel, then let a pending tap loop finish
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (exp_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_frame(int w, int h, int r);
      write_reg(CSR_WIDTH, 13'(w));
      write_reg(CSR_HEIGHT, 13'(h));
      write_reg(CSR_RADIUS, 13'(r));
   endtask

   task automatic load_random_kernel();
      for (int i = 0; i < GRID * GRID; i++) begin
         // mostly modest taps so sums land inside 0..255 often
         if ($urandom_range(3) == 0) send_coef(6'(i), 16'($urandom));
         else send_coef(6'(i), 16'($urandom_range(1200)) - 16'd300);
      end
   endtask

   task automatic flush_all();
      while (frame_rcvd) send_flush();
   endtask

   // receiver stalls
   always @(negedge clock) rsp_tready = ($urandom_range(99) >= receiver_idle);

   // result checker
   always @(posedge clock) begin
      pixel_out_t want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tlast};
         if (exp_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result rgb=%h/%h/%h last=%b",
                        got.red, got.green, got.blue, got.last);
         end else begin
            want = exp_pixels.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected rgb=%h/%h/%h last=%b, got rgb=%h/%h/%h last=%b",
                           want.red, want.green, want.blue, want.last,
                           got.red, got.green, got.blue, got.last);
            end
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         stall_count <= 0;
      else if (stall_count >= LIMIT) begin
         $display("timeout with %0d results outstanding", exp_pixels.size());
         $display("tb_rgb_window_convolution failed");
         $finish;
      end else
         stall_count <= stall_count + 1;
   end

   // kernel loads, with ignored kinds: bad coefficient index, unused request type, early flush
   task automatic test_kernel_load();
      send_coef(6'd0, 16'h8000);
      send_coef(6'd48, 16'h7FFF);
      send_coef(6'd63, 16'h1234);
      send_coef(6'd49, 16'hFFFF);
      send_item(REQ_NONE, 48'hFFFF_FFFF_FFFF);
      send_flush();
      for (int i = 0; i < GRID * GRID; i++) kernel[i] = kernel[i];
      send_coef(6'd4, 16'h1000);   // tap 4, outside the grid used at radius 1, unity gain
      send_coef(6'd0, 16'h0000);
      send_coef(6'd48, 16'h0000);
   endtask

   // 3x3 image, radius 1, pixel extremes; outputs lag by a row and a pixel
   task automatic test_small_frame();
      set_frame(3, 3, 1);
      send_coef(6'd5, 16'hF000);   // negative tap, outside the grid used at radius 1
      for (int i = 0; i < 9; i++)
         send_pixel((i % 2) ? 8'hFF : 8'h00, 8'(i * 31), (i % 3) ? 8'hFF : 8'h00);
      send_flush();                // pending outputs only after the frame
      flush_all();
      send_flush();                // nothing pending: ignored
      drain();
   endtask

   // a new frame started while outputs of the old one are still waiting
   task automatic test_pending_dropped();
      set_frame(2, 2, 1);
      send_coef(6'd8, 16'h7FFF);
      repeat (4) send_pixel(8'hFF, 8'h80, 8'h01);
      repeat (4) send_pixel(8'h10, 8'h20, 8'h30);
      flush_all();
      drain();
   endtask

   // register values at and beyond their limits
   task automatic test_register_extremes();
      set_frame(0, 0, 0);          // zero width and height behave as one
      send_pixel(8'hAB, 8'hCD, 8'hEF);
      drain();
      set_frame(2047, 8191, 3);    // wider than the store, taller than allowed
      set_frame(1, 4096, 2);
      set_frame(0, 1, 2);
      send_pixel(8'h7F, 8'h80, 8'hFF);
      flush_all();
      drain();
   endtask

   task automatic random_frame();
      int w, h, r, extra;
      w = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(12, 1);
      h = $urandom_range(8, 1);
      r = $urandom_range(3);
      set_frame(w, h, r);
      if ($urandom_range(2) == 0) load_random_kernel();
      for (int i = 0; i < w * h; i++) begin
         case ($urandom_range(19))
            0: send_coef(6'($urandom_range(48)), 16'($urandom));
            1: send_item(REQ_NONE, 48'({$urandom, $urandom}));
            2: send_coef(6'($urandom_range(63, 49)), 16'($urandom));
            3: send_flush();   // frame not complete yet
            default: ;
         endcase
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      end
      // usually drain everything; sometimes leave outputs for the next frame to drop
      if ($urandom_range(4) == 0) begin
         extra = $urandom_range(w * h);
         for (int i = 0; i < extra && frame_rcvd; i++) send_flush();
         if ($urandom_range(1)) begin
            w = w;
            for (int i = 0; i < w * h; i++)
               send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
         end
      end
      flush_all();
      drain();
   endtask

   task automatic test_random_traffic();
      int goal;
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle = (phase == 0) ? 38 : (phase == 1) ? 76 : 0;
         receiver_idle = (phase == 0) ? 76 : (phase == 1) ? 38 : 0;
         goal = item_count + 160;
         while (item_count < goal) random_frame();
      end
   endtask

   initial begin
      for (int i = 0; i < MAX_W * SLOTS; i++) pix_store[i] = '0;
      for (int i = 0; i < NCOEF; i++) kernel[i] = '0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      frame_rcvd = 0;
      cfg_width = 11'd640;
      cfg_height = 13'd480;
      cfg_radius = 2'd1;
      item_count = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_kernel_load();
      test_small_frame();
      test_pending_dropped();
      test_register_extremes();
      item_count = 0;
      test_random_traffic();
      drain();

      if (mismatches == 0 && exp_pixels.size() == 0)
         $display("tb_rgb_window_convolution passed");
      else
         $display("tb_rgb_window_convolution failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/rwc_pkg.sv
src/rwc_mac.sv
src/rgb_window_convolution.sv
src/rwc_checker.sv
tb/sv/tb_rgb_window_convolution.sv
